// File: rtl/mpb_pkg.sv
// Shared types, constants and helpers for the magnetic pendulum basin simulator.
package mpb_pkg;

  localparam int WIDE = 97;
  localparam int SUM_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_BACK       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SQ       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ABORT_SPEED_SQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ABORT_RADIUS_SQ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEPS       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS       = 3'd7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SIM  = 1'b1;

  // floor(n / 3) = (n * RECIP_THREE) >> DIV3_SHIFT, exact for n < 2^33
  localparam logic signed [63:0] RECIP_THREE = 64'sh0000_0000_aaaa_aaab;
  localparam int DIV3_SHIFT = 33;
  localparam logic [63:0] C_LIMIT = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    ARITH_MUL  = 2'd0,
    ARITH_DIV  = 2'd1,
    ARITH_SQRT = 2'd2
  } arith_op_t;

  typedef struct packed {
    arith_op_t          op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] strength;
  } magnet_t;

  typedef struct packed {
    logic    en;
    logic    enable;
    magnet_t entry;
  } table_wr_t;

  typedef struct packed {
    logic               operation;
    logic [2:0]         magnet_slot;
    logic               magnet_enable;
    logic signed [31:0] magnet_x;
    logic signed [31:0] magnet_y;
    logic signed [31:0] magnet_strength;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic             captured;
    logic [2:0]       magnet_index;
    logic [SUM_W-1:0] speed_sum;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
    logic signed [31:0] r;
    if ((&v[WIDE-1:31]) || !(|v[WIDE-1:31])) r = v[31:0];
    else if (v[WIDE-1]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

endpackage

// File: rtl/mpb_in_if.sv
// Request channel interfaces for items in and results out.
interface mpb_in_if import mpb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mpb_out_if import mpb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/mpb_arith.sv
// Shared multi-cycle arithmetic unit: 64x32 multiply, 64/64 divide, 64-bit square root.
module mpb_arith import mpb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  arith_req_t             req,
  output logic                   done,
  output logic signed [WIDE-1:0] res
);

  arith_op_t   op_r;
  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic        sign_r;
  logic [63:0] amag_r;
  logic [63:0] bmag_r;
  logic [95:0] acc_r;
  logic [64:0] rem_r;
  logic [31:0] root_r;
  logic [33:0] srem_r;

  logic        last;
  logic [31:0] mhalf;
  logic [63:0] pp;
  logic [64:0] rem_sh;
  logic [35:0] srem_sh;
  logic [35:0] trial;

  always_comb begin
    unique case (op_r)
      ARITH_MUL:  last = (cnt_r == 6'd1);
      ARITH_DIV:  last = (cnt_r == 6'd63);
      ARITH_SQRT: last = (cnt_r == 6'd31);
      default:    last = 1'b1;
    endcase
    mhalf   = cnt_r[0] ? amag_r[63:32] : amag_r[31:0];
    pp      = mhalf * bmag_r[31:0];
    rem_sh  = {rem_r[63:0], amag_r[63]};
    srem_sh = {srem_r, amag_r[63:62]};
    trial   = {2'b00, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= req.op;
      cnt_r  <= '0;
      sign_r <= req.a[63] ^ req.b[63];
      // square root takes its operand unsigned
      amag_r <= (req.a[63] && req.op != ARITH_SQRT) ? 64'(-req.a) : 64'(req.a);
      bmag_r <= req.b[63] ? 64'(-req.b) : 64'(req.b);
      acc_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
      srem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      unique case (op_r)
        ARITH_MUL: begin
          if (cnt_r[0]) acc_r <= acc_r + {pp, 32'd0};
          else acc_r <= acc_r + 96'(pp);
        end
        ARITH_DIV: begin
          if (rem_sh >= {1'b0, bmag_r}) begin
            rem_r  <= rem_sh - {1'b0, bmag_r};
            amag_r <= {amag_r[62:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            amag_r <= {amag_r[62:0], 1'b0};
          end
        end
        ARITH_SQRT: begin
          amag_r <= {amag_r[61:0], 2'b00};
          if (srem_sh >= trial) begin
            srem_r <= 34'(srem_sh - trial);
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            srem_r <= srem_sh[33:0];
            root_r <= {root_r[30:0], 1'b0};
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  always_comb begin
    unique case (op_r)
      ARITH_MUL:  res = sign_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
      ARITH_DIV:  res = WIDE'(sign_r ? -$signed({1'b0, amag_r}) : $signed({1'b0, amag_r}));
      ARITH_SQRT: res = WIDE'({1'b0, root_r});
      default:    res = '0;
    endcase
  end

  assign done = done_r;

endmodule

// File: rtl/mpb_table.sv
// Magnet table: synchronous memory for positions and strengths, valid bits in flops.
module mpb_table import mpb_pkg::*; #(
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  table_wr_t        wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [AW-1:0]    rd_addr,
  output magnet_t          rd_data,
  output logic [DEPTH-1:0] valid
);

  magnet_t          mem [DEPTH];
  magnet_t          rd_data_r;
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr_addr] <= wr.entry;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (wr.en) valid_r[wr_addr] <= wr.enable;
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;

endmodule

// File: rtl/magnetic_pendulum_basin_sim.sv
// Top level: sequencer that integrates the pendulum over the magnet table.
// Load request: no result. Simulate request: the work per step grows with each disabled slot
// and each enabled magnet (one shared multiply/divide/sqrt unit), times the steps run, and
// the result is posted at the end.
// One request at a time. Synchronous active-low reset clears control, valid bits, config regs.
module magnetic_pendulum_basin_sim import mpb_pkg::*; #(
  parameter int MAX_MAGNETS = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mpb_in_if.sink                in_ch,
  mpb_out_if.source             out_ch
);

  localparam int AW = (MAX_MAGNETS > 1) ? $clog2(MAX_MAGNETS) : 1;
  localparam int CNT_W = $clog2(MAX_MAGNETS + 1);
  localparam int ACC_W = 50;
  localparam int R_W = 65 - FRAC_BITS;

  typedef enum logic [20:0] {
    ST_IDLE  = 21'd1 << 0,
    ST_BEGIN = 21'd1 << 1,
    ST_MSEL  = 21'd1 << 2,
    ST_MLOAD = 21'd1 << 3,
    ST_DXX   = 21'd1 << 4,
    ST_DYY   = 21'd1 << 5,
    ST_SQ    = 21'd1 << 6,
    ST_RQ    = 21'd1 << 7,
    ST_SD    = 21'd1 << 8,
    ST_DIV   = 21'd1 << 9,
    ST_DAMP  = 21'd1 << 10,
    ST_BDIV  = 21'd1 << 11,
    ST_BMUL  = 21'd1 << 12,
    ST_TDIV  = 21'd1 << 13,
    ST_TMUL  = 21'd1 << 14,
    ST_VMUL  = 21'd1 << 15,
    ST_WMUL  = 21'd1 << 16,
    ST_VX2   = 21'd1 << 17,
    ST_VY2   = 21'd1 << 18,
    ST_VSQRT = 21'd1 << 19,
    ST_DONE  = 21'd1 << 20
  } state_t;

  state_t state_r, state_nxt;

  logic [30:0] friction_r, pull_back_r, step_size_r;
  logic [31:0] height_sq_r, abort_speed_sq_r, abort_radius_sq_r;
  logic [15:0] min_steps_r, max_steps_r;

  logic                    issued_r;
  logic [15:0]             step_r;
  logic [CNT_W-1:0]        j_r;
  logic                    axis_r;
  logic [1:0]              k_r;
  logic signed [31:0]      px_r, py_r, vx_r, vy_r;
  logic signed [31:0]      a0x_r, a0y_r, a1x_r, a1y_r;
  logic signed [ACC_W-1:0] ax_r, ay_r, u_r;
  logic signed [31:0]      dx_r, dy_r, str_r, t_r;
  logic [63:0]             sq_r, vsq_r, c_r;
  logic [R_W-1:0]          r_r;
  logic [31:0]             q_r;
  logic signed [63:0]      quo_r;
  logic [SUM_W-1:0]        sum_r;
  logic                    res_cap_r;
  logic [2:0]              res_idx_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  logic                   arith_start, arith_done;
  arith_req_t             arith_req;
  logic signed [WIDE-1:0] ares, ashr;

  table_wr_t        twr;
  magnet_t          trd;
  logic [MAX_MAGNETS-1:0] tvalid;
  logic [AW-1:0]    jaddr;

  logic               in_fire, out_free, j_end, steps_done, slow, hit, skip, ovf;
  logic [63:0]        d2, cfull, c1;
  logic signed [31:0] vsel, psel, a_cur, a1_sel, a0_sel;
  logic signed [39:0] bnum, tnum;
  logic signed [39:0] dnum;
  logic [39:0]        dmag;
  logic [31:0]        dquo;
  logic [SUM_W:0]     sum_ext;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign jaddr    = j_r[AW-1:0];
  assign j_end    = (j_r == CNT_W'(MAX_MAGNETS));
  assign steps_done = (step_r >= max_steps_r);
  assign slow     = ((vsq_r >> FRAC_BITS) < 64'(abort_speed_sq_r));
  assign ashr     = ares >>> FRAC_BITS;
  assign d2       = (sq_r + ares[63:0]) >> FRAC_BITS;
  assign hit      = (step_r >= min_steps_r) && (d2 < 64'(abort_radius_sq_r)) && slow;
  assign ovf      = |ares[WIDE-2:64];
  assign cfull    = ares[63:0] >> FRAC_BITS;
  assign c1       = (cfull == 64'd0) ? 64'd1 : cfull;
  assign skip     = ovf || (c1 > C_LIMIT);
  assign vsel     = axis_r ? vy_r : vx_r;
  assign psel     = axis_r ? py_r : px_r;
  assign a_cur    = axis_r ? $signed(ay_r[31:0]) : $signed(ax_r[31:0]);
  assign a1_sel   = axis_r ? a1y_r : a1x_r;
  assign a0_sel   = axis_r ? a0y_r : a0x_r;
  assign bnum     = (40'(a_cur) <<< 1) + (40'(a1_sel) <<< 2) + 40'(a1_sel) - 40'(a0_sel);
  assign tnum     = (40'(a1_sel) <<< 2) - 40'(a0_sel);
  // divide by six: halve the magnitude, multiply by the reciprocal of three
  assign dnum     = (state_r == ST_TDIV) ? tnum : bnum;
  assign dmag     = dnum[39] ? 40'(-dnum) : 40'(dnum);
  assign dquo     = ares[DIV3_SHIFT+31:DIV3_SHIFT];
  assign sum_ext  = {1'b0, sum_r} + (SUM_W + 1)'(ares[31:0]);

  assign twr.en           = in_fire && (in_ch.payload.operation == OP_LOAD) &&
                            (32'(in_ch.payload.magnet_slot) < MAX_MAGNETS);
  assign twr.enable       = in_ch.payload.magnet_enable;
  assign twr.entry.x      = in_ch.payload.magnet_x;
  assign twr.entry.y      = in_ch.payload.magnet_y;
  assign twr.entry.strength = in_ch.payload.magnet_strength;

  mpb_table #(.DEPTH(MAX_MAGNETS)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (twr),
    .wr_addr (AW'(in_ch.payload.magnet_slot)),
    .rd_addr (jaddr),
    .rd_data (trd),
    .valid   (tvalid)
  );

  mpb_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (arith_start),
    .req   (arith_req),
    .done  (arith_done),
    .res   (ares)
  );

  always_comb begin
    logic is_op;
    is_op = 1'b1;
    arith_req.op = ARITH_MUL;
    arith_req.a  = '0;
    arith_req.b  = '0;
    unique case (state_r)
      ST_DXX: begin
        arith_req.a = 64'(dx_r);
        arith_req.b = 64'(dx_r);
      end
      ST_DYY: begin
        arith_req.a = 64'(dy_r);
        arith_req.b = 64'(dy_r);
      end
      ST_SQ: begin
        arith_req.op = ARITH_SQRT;
        arith_req.a  = 64'(r_r) << FRAC_BITS;
      end
      ST_RQ: begin
        arith_req.a = 64'(r_r);
        arith_req.b = 64'(q_r);
      end
      ST_SD: begin
        arith_req.a = 64'(str_r);
        arith_req.b = axis_r ? 64'(dy_r) : 64'(dx_r);
      end
      ST_DIV: begin
        arith_req.op = ARITH_DIV;
        arith_req.a  = quo_r;
        arith_req.b  = c_r;
      end
      ST_DAMP: begin
        arith_req.a = k_r[1] ? (k_r[0] ? 64'(py_r) : 64'(px_r))
                             : (k_r[0] ? 64'(vy_r) : 64'(vx_r));
        arith_req.b = k_r[1] ? 64'(pull_back_r) : 64'(friction_r);
      end
      ST_BDIV, ST_TDIV: begin
        arith_req.a = 64'(dmag[39:1]);
        arith_req.b = RECIP_THREE;
      end
      ST_BMUL, ST_TMUL: begin
        arith_req.a = quo_r;
        arith_req.b = 64'(step_size_r);
      end
      ST_VMUL: begin
        arith_req.a = 64'(vsel);
        arith_req.b = 64'(step_size_r);
      end
      ST_WMUL: begin
        arith_req.a = 64'(t_r);
        arith_req.b = 64'(step_size_r);
      end
      ST_VX2: begin
        arith_req.a = 64'(vx_r);
        arith_req.b = 64'(vx_r);
      end
      ST_VY2: begin
        arith_req.a = 64'(vy_r);
        arith_req.b = 64'(vy_r);
      end
      ST_VSQRT: begin
        arith_req.op = ARITH_SQRT;
        arith_req.a  = vsq_r;
      end
      default: is_op = 1'b0;
    endcase
    arith_start = is_op && !issued_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && in_ch.payload.operation == OP_SIM) state_nxt = ST_BEGIN;
      ST_BEGIN: state_nxt = steps_done ? ST_DONE : ST_MSEL;
      ST_MSEL: begin
        if (j_end) state_nxt = ST_DAMP;
        else if (tvalid[jaddr]) state_nxt = ST_MLOAD;
      end
      ST_MLOAD: state_nxt = ST_DXX;
      ST_DXX:   if (arith_done) state_nxt = ST_DYY;
      ST_DYY:   if (arith_done) state_nxt = hit ? ST_DONE : ST_SQ;
      ST_SQ:    if (arith_done) state_nxt = ST_RQ;
      ST_RQ:    if (arith_done) state_nxt = skip ? ST_MSEL : ST_SD;
      ST_SD:    if (arith_done) state_nxt = ST_DIV;
      ST_DIV:   if (arith_done) state_nxt = axis_r ? ST_MSEL : ST_SD;
      ST_DAMP:  if (arith_done && k_r == 2'd3) state_nxt = ST_BDIV;
      ST_BDIV:  if (arith_done) state_nxt = ST_BMUL;
      ST_BMUL:  if (arith_done) state_nxt = axis_r ? ST_TDIV : ST_BDIV;
      ST_TDIV:  if (arith_done) state_nxt = ST_TMUL;
      ST_TMUL:  if (arith_done) state_nxt = ST_VMUL;
      ST_VMUL:  if (arith_done) state_nxt = ST_WMUL;
      ST_WMUL:  if (arith_done) state_nxt = axis_r ? ST_VX2 : ST_TDIV;
      ST_VX2:   if (arith_done) state_nxt = ST_VY2;
      ST_VY2:   if (arith_done) state_nxt = ST_VSQRT;
      ST_VSQRT: if (arith_done) state_nxt = ST_BEGIN;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (arith_done) issued_r <= 1'b0;
      else if (arith_start) issued_r <= 1'b1;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_r        <= 31'd13107;
      pull_back_r       <= 31'd13107;
      step_size_r       <= 31'd655;
      height_sq_r       <= 32'd4096;
      abort_speed_sq_r  <= 32'd655;
      abort_radius_sq_r <= 32'd6554;
      min_steps_r       <= 16'd0;
      max_steps_r       <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRICTION:        friction_r        <= cfg_data[30:0];
        CFG_PULL_BACK:       pull_back_r       <= cfg_data[30:0];
        CFG_STEP_SIZE:       step_size_r       <= cfg_data[30:0];
        CFG_HEIGHT_SQ:       height_sq_r       <= cfg_data;
        CFG_ABORT_SPEED_SQ:  abort_speed_sq_r  <= cfg_data;
        CFG_ABORT_RADIUS_SQ: abort_radius_sq_r <= cfg_data;
        CFG_MIN_STEPS:       min_steps_r       <= cfg_data[15:0];
        CFG_MAX_STEPS:       max_steps_r       <= cfg_data[15:0];
        default:             friction_r        <= friction_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        px_r <= in_ch.payload.start_x;
        py_r <= in_ch.payload.start_y;
        vx_r <= '0;
        vy_r <= '0;
        a0x_r <= '0;
        a0y_r <= '0;
        a1x_r <= '0;
        a1y_r <= '0;
        vsq_r <= '0;
        sum_r <= '0;
        step_r <= '0;
        res_cap_r <= 1'b0;
        res_idx_r <= '0;
      end
      ST_BEGIN: begin
        ax_r <= '0;
        ay_r <= '0;
        j_r  <= '0;
        k_r  <= '0;
      end
      ST_MSEL: if (!j_end && !tvalid[jaddr]) j_r <= j_r + CNT_W'(1);
      ST_MLOAD: begin
        dx_r  <= sat32(WIDE'(trd.x) - WIDE'(px_r));
        dy_r  <= sat32(WIDE'(trd.y) - WIDE'(py_r));
        str_r <= trd.strength;
      end
      ST_DXX: if (arith_done) sq_r <= ares[63:0];
      ST_DYY: begin
        if (arith_done) begin
          r_r <= R_W'(d2 + 64'(height_sq_r));
          if (hit) begin
            res_cap_r <= 1'b1;
            res_idx_r <= 3'(j_r);
          end
        end
      end
      ST_SQ: if (arith_done) q_r <= ares[31:0];
      ST_RQ: begin
        if (arith_done) begin
          c_r    <= c1;
          axis_r <= 1'b0;
          if (skip) j_r <= j_r + CNT_W'(1);
        end
      end
      ST_SD: if (arith_done) quo_r <= ares[63:0];
      ST_DIV: begin
        if (arith_done) begin
          if (axis_r) begin
            ay_r <= ay_r + ACC_W'(sat32(ares));
            j_r  <= j_r + CNT_W'(1);
          end else begin
            ax_r <= ax_r + ACC_W'(sat32(ares));
          end
          axis_r <= !axis_r;
        end
      end
      ST_DAMP: begin
        if (arith_done) begin
          k_r <= k_r + 2'd1;
          axis_r <= 1'b0;
          if (k_r[0]) begin
            if (k_r[1]) ay_r <= ACC_W'(sat32(WIDE'(ay_r) - ashr));
            else ay_r <= ay_r - ACC_W'(ashr);
          end else begin
            if (k_r[1]) ax_r <= ACC_W'(sat32(WIDE'(ax_r) - ashr));
            else ax_r <= ax_r - ACC_W'(ashr);
          end
        end
      end
      ST_BDIV, ST_TDIV: begin
        if (arith_done) begin
          quo_r <= dnum[39] ? -$signed({32'd0, dquo}) : $signed({32'd0, dquo});
        end
      end
      ST_BMUL: begin
        if (arith_done) begin
          if (axis_r) begin
            vy_r  <= sat32(WIDE'(vy_r) + ashr);
            a0x_r <= a1x_r;
            a0y_r <= a1y_r;
            a1x_r <= $signed(ax_r[31:0]);
            a1y_r <= $signed(ay_r[31:0]);
          end else begin
            vx_r <= sat32(WIDE'(vx_r) + ashr);
          end
          axis_r <= !axis_r;
        end
      end
      ST_TMUL: if (arith_done) t_r <= sat32(ashr);
      ST_VMUL: if (arith_done) u_r <= ACC_W'(ashr);
      ST_WMUL: begin
        if (arith_done) begin
          if (axis_r) py_r <= sat32(WIDE'(py_r) + WIDE'(u_r) + ashr);
          else px_r <= sat32(WIDE'(px_r) + WIDE'(u_r) + ashr);
          axis_r <= !axis_r;
        end
      end
      ST_VX2: if (arith_done) sq_r <= ares[63:0];
      ST_VY2: if (arith_done) vsq_r <= sq_r + ares[63:0];
      ST_VSQRT: begin
        if (arith_done) begin
          sum_r  <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
          step_r <= step_r + 16'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_r.captured     <= res_cap_r;
          out_r.magnet_index <= res_idx_r;
          out_r.speed_sum    <= sum_r;
        end
      end
      default: step_r <= step_r;
    endcase
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

endmodule

// File: rtl/mpb_checker.sv
// Port-level checks for the basin simulator, bound to the top level.
module mpb_checker import mpb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mpb_in_if.sink    in_ch,
  mpb_out_if.source out_ch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.payload))
    else $error("result changed while stalled");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.payload.captured |-> out_ch.payload.magnet_index == 3'd0)
    else $error("index set without capture");

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_sim_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.payload.operation == OP_SIM |=> !in_ch.ready)
    else $error("request taken during simulation");

endmodule

bind magnetic_pendulum_basin_sim mpb_checker u_mpb_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// File: test/mpb_basin_checker.sv
// Checker: mirrors the registers and magnet table, predicts each simulate result and compares.
module mpb_basin_checker import mpb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mpb_in_if                     in_mon,
  mpb_out_if                    out_mon,
  output int                    errors,
  output int                    pending
);

  localparam longint unsigned SPEED_SUM_MAX = 64'h0000_ffff_ffff_ffff;

  longint unsigned friction_r, pull_back_r, dt_r, height_sq_r;
  longint unsigned speed_lim_r, radius_lim_r, min_steps_r, max_steps_r;
  longint mag_x [8];
  longint mag_y [8];
  longint mag_s [8];
  bit     mag_on [8];
  out_item_t outcome_q [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_sq(longint a, longint b);
    longint unsigned ua, ub;
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    return ua * ua + ub * ub;
  endfunction

  // inverse-cube pull along one axis
  function automatic longint pull(longint s, longint d, longint unsigned r);
    longint unsigned q, c;
    logic [127:0] p;
    q = isqrt(r << 16);
    p = {64'd0, r} * {64'd0, q};
    if (p[127:64] != 0) c = '1;
    else c = {16'd0, p[63:16]};
    if (c == 0) c = 1;
    if (c > 64'h4000_0000_0000_0000) return 0;
    return clamp32((s * d) / longint'(c));
  endfunction

  function automatic out_item_t integrate_bob(longint sx, longint sy);
    out_item_t res;
    longint px, py, vx, vy, a0x, a0y, a1x, a1y, ax, ay, bx, by, t, dx, dy, dt;
    longint unsigned sum, d2;
    bit slow;
    px = sx; py = sy;
    vx = 0; vy = 0; a0x = 0; a0y = 0; a1x = 0; a1y = 0;
    dt = longint'(dt_r);
    sum = 0;
    for (longint unsigned st = 0; st < max_steps_r; st++) begin
      ax = 0; ay = 0;
      slow = (mag_sq(vx, vy) >> 16) < speed_lim_r;
      for (int j = 0; j < 8; j++) begin
        if (mag_on[j]) begin
          dx = clamp32(mag_x[j] - px);
          dy = clamp32(mag_y[j] - py);
          d2 = mag_sq(dx, dy) >> 16;
          if (st >= min_steps_r && d2 < radius_lim_r && slow) begin
            res.captured = 1'b1;
            res.magnet_index = j[2:0];
            res.speed_sum = sum[SUM_W-1:0];
            return res;
          end
          d2 = d2 + height_sq_r;
          ax = ax + pull(mag_s[j], dx, d2);
          ay = ay + pull(mag_s[j], dy, d2);
        end
      end
      ax = ax - ((vx * longint'(friction_r)) >>> 16);
      ay = ay - ((vy * longint'(friction_r)) >>> 16);
      ax = ax - ((px * longint'(pull_back_r)) >>> 16);
      ay = ay - ((py * longint'(pull_back_r)) >>> 16);
      ax = clamp32(ax);
      ay = clamp32(ay);
      bx = (2 * ax + 5 * a1x - a0x) / 6;
      by = (2 * ay + 5 * a1y - a0y) / 6;
      vx = clamp32(vx + ((bx * dt) >>> 16));
      vy = clamp32(vy + ((by * dt) >>> 16));
      a0x = a1x; a0y = a1y;
      a1x = ax; a1y = ay;
      t = clamp32((((4 * a1x - a0x) / 6) * dt) >>> 16);
      px = clamp32(px + ((vx * dt) >>> 16) + ((t * dt) >>> 16));
      t = clamp32((((4 * a1y - a0y) / 6) * dt) >>> 16);
      py = clamp32(py + ((vy * dt) >>> 16) + ((t * dt) >>> 16));
      sum = sum + isqrt(mag_sq(vx, vy));
      if (sum > SPEED_SUM_MAX) sum = SPEED_SUM_MAX;
    end
    res.captured = 1'b0;
    res.magnet_index = 3'd0;
    res.speed_sum = sum[SUM_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    int errs;
    in_item_t it;
    out_item_t want, got;
    errs = errors;
    if (!rst_n) begin
      friction_r = 13107; pull_back_r = 13107; dt_r = 655; height_sq_r = 4096;
      speed_lim_r = 655; radius_lim_r = 6554; min_steps_r = 0; max_steps_r = 1000;
      for (int j = 0; j < 8; j++) begin
        mag_x[j] = 0; mag_y[j] = 0; mag_s[j] = 0; mag_on[j] = 0;
      end
      outcome_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRICTION:        friction_r = cfg_data[30:0];
          CFG_PULL_BACK:       pull_back_r = cfg_data[30:0];
          CFG_STEP_SIZE:       dt_r = cfg_data[30:0];
          CFG_HEIGHT_SQ:       height_sq_r = cfg_data;
          CFG_ABORT_SPEED_SQ:  speed_lim_r = cfg_data;
          CFG_ABORT_RADIUS_SQ: radius_lim_r = cfg_data;
          CFG_MIN_STEPS:       min_steps_r = cfg_data[15:0];
          CFG_MAX_STEPS:       max_steps_r = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        it = in_mon.payload;
        if (it.operation == OP_LOAD) begin
          mag_on[it.magnet_slot] = it.magnet_enable;
          mag_x[it.magnet_slot] = it.magnet_x;
          mag_y[it.magnet_slot] = it.magnet_y;
          mag_s[it.magnet_slot] = it.magnet_strength;
        end else begin
          outcome_q.push_back(integrate_bob(it.start_x, it.start_y));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = outcome_q.pop_front();
          if (got.captured !== want.captured) begin
            $error("captured: expected %0d actual %0d", want.captured, got.captured);
            errs++;
          end
          if (got.magnet_index !== want.magnet_index) begin
            $error("magnet_index: expected %0d actual %0d", want.magnet_index,
                   got.magnet_index);
            errs++;
          end
          if (got.speed_sum !== want.speed_sum) begin
            $error("speed_sum: expected %0d actual %0d", want.speed_sum, got.speed_sum);
            errs++;
          end
        end
      end
    end
    errors <= errs;
    pending <= outcome_q.size();
  end

endmodule

// File: test/tb_magnetic_pendulum_basin_sim.sv
// Testbench top: clock, reset, register phases, request stimulus, result sink and verdict.
module tb_magnetic_pendulum_basin_sim;
  import mpb_pkg::*;

  localparam int LIMIT = 10_000_000;

  logic                  clk = 0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors, pending;
  int                    cyc = 0;
  int                    results_seen = 0;
  int                    hold_left = 0;
  bit                    held = 0;
  bit                    burst = 0;

  mpb_in_if  in_ch ();
  mpb_out_if out_ch ();

  magnetic_pendulum_basin_sim uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  mpb_basin_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
    .errors(errors), .pending(pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result sink: random idling, one long hold-off, a quiet window
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!held && results_seen == 6) begin
        held <= 1;
        hold_left <= 3000;
        out_ch.ready <= 1'b0;
      end else if (cyc > 60000 && cyc < 160000) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  function automatic logic [31:0] coord();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 393216) - 196608;
  endfunction

  function automatic in_item_t mk_load(logic [2:0] slot, logic en, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] s);
    in_item_t it;
    it.operation = OP_LOAD;
    it.magnet_slot = slot;
    it.magnet_enable = en;
    it.magnet_x = x;
    it.magnet_y = y;
    it.magnet_strength = s;
    it.start_x = $urandom();
    it.start_y = $urandom();
    return it;
  endfunction

  function automatic in_item_t mk_sim(logic [31:0] x, logic [31:0] y);
    in_item_t it;
    it.operation = OP_SIM;
    it.magnet_slot = 3'($urandom());
    it.magnet_enable = 1'($urandom());
    it.magnet_x = $urandom();
    it.magnet_y = $urandom();
    it.magnet_strength = $urandom();
    it.start_x = x;
    it.start_y = y;
    return it;
  endfunction

  task automatic send(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (!burst && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic wr(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] fr, logic [31:0] pb, logic [31:0] dt,
                          logic [31:0] hs, logic [31:0] sp, logic [31:0] rad,
                          logic [31:0] mn, logic [31:0] mx);
    wait_idle();
    wr(CFG_FRICTION, fr);
    wr(CFG_PULL_BACK, pb);
    wr(CFG_STEP_SIZE, dt);
    wr(CFG_HEIGHT_SQ, hs);
    wr(CFG_ABORT_SPEED_SQ, sp);
    wr(CFG_ABORT_RADIUS_SQ, rad);
    wr(CFG_MIN_STEPS, mn);
    wr(CFG_MAX_STEPS, mx);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick(int unsigned lo, int unsigned hi);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $urandom_range(lo, hi);
  endfunction

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(mk_load(3'd0, 1'b1, 32'h0001_0000, 32'h0, 32'h0001_0000));
    send(mk_load(3'd1, 1'b1, 32'hffff_0000, 32'h0000_8000, 32'h0002_0000));
    send(mk_load(3'd2, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    send(mk_load(3'd7, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    set_regs(13107, 13107, 6554, 4096, 655, 6554, 0, 6);
    send(mk_sim(32'h0, 32'h0));
    send(mk_sim(32'h0001_0000, 32'h0));
    send(mk_sim(32'h8000_0000, 32'h7fff_ffff));
    send(mk_sim(32'h7fff_ffff, 32'h8000_0000));
    // everything huge: capture at the first step before any integration
    set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
             32'hffff_ffff, 32'hffff_ffff, 0, 16'hffff);
    send(mk_sim(32'h0001_0000, 32'h0));
    send(mk_sim(32'h0000_4000, 32'hffff_c000));
    // no capture possible, zero height gives a zero root at the magnet
    set_regs(0, 0, 1, 0, 0, 0, 16'hffff, 3);
    send(mk_sim(32'h0001_0000, 32'h0));
    send(mk_sim(32'h8000_0000, 32'h8000_0000));
    send(mk_sim(32'h7fff_ffff, 32'h7fff_ffff));
    send(mk_load(3'd7, 1'b0, 32'h0, 32'h0, 32'h0));
    send(mk_sim(32'h0, 32'h0002_0000));
    // zero step limit
    set_regs(100, 200, 655, 4096, 655, 6554, 0, 0);
    send(mk_sim(32'h0001_0000, 32'h0));
    send(mk_sim(32'h1234_5678, 32'h8765_4321));

    for (int ph = 0; ph < 5; ph++) begin
      set_regs(pick(0, 40000), pick(0, 40000), pick(1, 20000), pick(0, 20000),
               pick(0, 200000), pick(0, 400000), $urandom_range(0, 4),
               $urandom_range(0, 8));
      for (int k = 0; k < 23; k++) begin
        burst = (ph == 2);
        if ($urandom_range(0, 9) < 3)
          send(mk_load(3'($urandom()), ($urandom_range(0, 3) != 0), coord(), coord(),
                       coord()));
        else
          send(mk_sim(coord(), coord()));
      end
      burst = 0;
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
